// ----- hw/rtl/sit_pkg.sv -----
// Package with shared widths and the transaction type for the segment intersection test.
package sit_pkg;
  localparam int CoordBits = 16;
  localparam int FracBits = 16;
  localparam int DiffBits = CoordBits + 1;
  localparam int ProdBits = 2 * DiffBits;
  localparam int CrossBits = ProdBits + 1;
  localparam int MagBits = CrossBits - 1;
  localparam int QuoBits = FracBits + 1;
  localparam int NumCells = FracBits + 1;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [MagBits-1:0]   rem;
    logic [MagBits-1:0]   den;
    logic [QuoBits-1:0]   quo;
  } div_t;
endpackage

// ----- hw/rtl/sit_front.sv -----
// Front end that forms the cross products, the hit decision and the divider operands.
module sit_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_a_start_x,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_a_start_y,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_a_end_x,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_a_end_y,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_b_start_x,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_b_start_y,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_b_end_x,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_b_end_y,
  output sit_pkg::div_t                        div_out
);
  localparam int D = sit_pkg::DiffBits;
  localparam int P = sit_pkg::ProdBits;
  localparam int X = sit_pkg::CrossBits;
  localparam int M = sit_pkg::MagBits;

  logic signed [D-1:0] ax, ay, bx, by, cx, cy;
  logic signed [P-1:0] p0, p1, p2, p3, p4, p5;
  logic                v1;
  logic signed [X-1:0] den, na, nb;
  logic                hit_c;
  logic [M-1:0]        mden, mna;
  sit_pkg::div_t       div_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      div_out.valid <= 1'b0;
    end else begin
      v1 <= start;
      div_out.valid <= div_next.valid;
    end
    p0 <= ax * by;
    p1 <= ay * bx;
    p2 <= ax * cy;
    p3 <= ay * cx;
    p4 <= bx * cy;
    p5 <= by * cx;
    div_out.hit <= div_next.hit;
    div_out.rem <= div_next.rem;
    div_out.den <= div_next.den;
    div_out.quo <= div_next.quo;
  end

  always_comb begin
    ax = D'(seg_a_end_x) - D'(seg_a_start_x);
    ay = D'(seg_a_end_y) - D'(seg_a_start_y);
    bx = D'(seg_b_end_x) - D'(seg_b_start_x);
    by = D'(seg_b_end_y) - D'(seg_b_start_y);
    cx = D'(seg_b_end_x) - D'(seg_a_end_x);
    cy = D'(seg_b_end_y) - D'(seg_a_end_y);
    den = X'(p0) - X'(p1);
    na = X'(p2) - X'(p3);
    nb = X'(p4) - X'(p5);
    if (den == '0) begin
      hit_c = 1'b0;
    end else if (den < 0) begin
      hit_c = !(na > 0 || na < den || nb > 0 || nb < den);
    end else begin
      hit_c = !(na < 0 || na > den || nb < 0 || nb > den);
    end
    mden = den[X-1] ? M'(-den) : M'(den);
    mna = na[X-1] ? M'(-na) : M'(na);
    div_next.valid = v1;
    div_next.hit = hit_c;
    div_next.den = hit_c ? mden : M'(1);
    div_next.rem = hit_c ? (mden - mna) : '0;
    div_next.quo = '0;
  end
endmodule

// ----- hw/rtl/sit_cell.sv -----
// One restoring division cell that produces one quotient bit and passes on the remainder.
module sit_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          first,
  input  sit_pkg::div_t din,
  output sit_pkg::div_t dout
);
  localparam int M = sit_pkg::MagBits;

  logic [M:0]   shifted;
  logic [M:0]   diff;
  logic         ge;

  always_comb begin
    shifted = first ? {1'b0, din.rem} : {din.rem, 1'b0};
    diff = shifted - {1'b0, din.den};
    ge = !diff[M];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.hit <= din.hit;
    dout.den <= din.den;
    dout.rem <= ge ? diff[M-1:0] : shifted[M-1:0];
    dout.quo <= {din.quo[sit_pkg::QuoBits-2:0], ge};
  end
endmodule

// ----- hw/rtl/segment_intersection_test_top.sv -----
// Top level of the segment intersection test: cross product front end and divider chain.
// Usage: drive the eight signed Q12.4 coordinates and pulse start to issue a transaction.
// busy is always low, so a new transaction may be issued on every clock cycle.
// The front end registers the products, then the cross differences and the hit
// test, then a chain of 17 restoring division cells produces one quotient bit
// each, one cell after the other.
// The result strobe done is the valid flag of the last cell, so a transaction passes
// the front end registers and every cell register before done rises.
// Throughput is one transaction per cycle, set by the cell chain pipeline.
// Each result shows hit and fraction for exactly one cycle while done is high;
// fraction is zero on a miss. Results leave in issue order.
// A synchronous reset clears all valid flags so no false strobe follows.
// The receiver cannot stall, so no result is ever held back.
module segment_intersection_test_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_a_start_x,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_a_start_y,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_a_end_x,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_a_end_y,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_b_start_x,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_b_start_y,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_b_end_x,
  input  logic signed [sit_pkg::CoordBits-1:0] seg_b_end_y,
  output logic                                 done,
  output logic                                 hit,
  output logic [sit_pkg::QuoBits-1:0]          fraction
);
  sit_pkg::div_t chain [sit_pkg::NumCells+1];

  assign busy = 1'b0;

  sit_front u_front (
    .clk(clk), .rst(rst), .start(start),
    .seg_a_start_x(seg_a_start_x), .seg_a_start_y(seg_a_start_y),
    .seg_a_end_x(seg_a_end_x), .seg_a_end_y(seg_a_end_y),
    .seg_b_start_x(seg_b_start_x), .seg_b_start_y(seg_b_start_y),
    .seg_b_end_x(seg_b_end_x), .seg_b_end_y(seg_b_end_y),
    .div_out(chain[0])
  );

  for (genvar i = 0; i < sit_pkg::NumCells; i++) begin : g_cell
    sit_cell u_cell (
      .clk(clk), .rst(rst), .first(i == 0),
      .din(chain[i]), .dout(chain[i+1])
    );
  end

  assign done = chain[sit_pkg::NumCells].valid;
  assign hit = chain[sit_pkg::NumCells].hit;
  assign fraction = chain[sit_pkg::NumCells].hit ? chain[sit_pkg::NumCells].quo : '0;
endmodule
